### rtl/slnm_pkg.sv
// Shared types and constants for the spectral line notch masker.
// Used by slnm_front, slnm_cell and spectral_line_notch_masker_core.
package slnm_pkg;

    localparam int MAX_LINES  = 16;
    localparam int BIN_W      = 28;
    localparam int POS_W      = 23;
    localparam int BINNUM_W   = 24;
    localparam int WING_MAX_W = 16;
    localparam int HZ_W       = 32;
    localparam int TB_W       = 32;
    localparam int PROD_W     = HZ_W + TB_W;
    localparam int SAMPLE_W   = 32;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_MIN_BIN       = 2'd0,
        REG_NUM_BINS      = 2'd1,
        REG_MAX_WING_BINS = 2'd2,
        REG_TIME_BASE     = 2'd3
    } reg_index_t;

    // Item moving down the cell chain: a line load, a clear or a sample.
    typedef struct packed {
        logic                       valid;
        cmd_t                       kind;
        logic                       taken;      // load already stored by a cell
        logic [BIN_W-1:0]           centre;
        logic [BIN_W-1:0]           left_bins;
        logic [BIN_W-1:0]           right_bins;
        logic signed [BIN_W:0]      lo_edge;    // centre - left wing
        logic [BIN_W:0]             hi_edge;    // centre + right wing
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic [BINNUM_W-1:0]        bin;
        logic                       last;
        logic                       hit;
    } token_t;

    // Band and wing limits seen by every cell.
    typedef struct packed {
        logic [POS_W-1:0]      lo;
        logic [BINNUM_W-1:0]   hi;
        logic [WING_MAX_W-1:0] max_wing;
    } band_t;

endpackage

### rtl/slnm_front.sv
// Entry stages: bin position counter, Hz-to-bin products and rounding.
// Depends on slnm_pkg; feeds the first slnm_cell.
module slnm_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [1:0]                             cmd,
    input  logic [slnm_pkg::HZ_W-1:0]              line_freq,
    input  logic [slnm_pkg::HZ_W-1:0]              left_wing,
    input  logic [slnm_pkg::HZ_W-1:0]              right_wing,
    input  logic signed [slnm_pkg::SAMPLE_W-1:0]   sample_re,
    input  logic signed [slnm_pkg::SAMPLE_W-1:0]   sample_im,
    input  logic [slnm_pkg::POS_W-1:0]             min_bin,
    input  logic [slnm_pkg::POS_W-1:0]             last_pos,
    input  logic [slnm_pkg::TB_W-1:0]              time_base,
    output slnm_pkg::token_t                       tok
);

    logic                                 a_valid_reg;
    slnm_pkg::cmd_t                       a_kind_reg;
    logic [slnm_pkg::PROD_W-1:0]          p_c_reg;
    logic [slnm_pkg::PROD_W-1:0]          p_l_reg;
    logic [slnm_pkg::PROD_W-1:0]          p_r_reg;
    logic signed [slnm_pkg::SAMPLE_W-1:0] a_re_reg;
    logic signed [slnm_pkg::SAMPLE_W-1:0] a_im_reg;
    logic [slnm_pkg::BINNUM_W-1:0]        a_bin_reg;
    logic                                 a_last_reg;
    logic [slnm_pkg::POS_W-1:0]           pos_reg;
    logic [slnm_pkg::POS_W-1:0]           pos_next;
    slnm_pkg::token_t                     tok_reg;
    slnm_pkg::token_t                     tok_next;

    logic                                 accept;
    logic                                 known_cmd;
    logic                                 is_sample;
    logic                                 is_last;
    logic [slnm_pkg::BIN_W+1:0]           c_up;
    logic [slnm_pkg::BIN_W:0]             c_full;
    logic [slnm_pkg::BIN_W-1:0]           centre;
    logic [slnm_pkg::BIN_W-1:0]           lw;
    logic [slnm_pkg::BIN_W-1:0]           rw;

    assign accept    = in_valid && en;
    assign known_cmd = (cmd == slnm_pkg::CMD_LOAD) || (cmd == slnm_pkg::CMD_SAMPLE)
                       || (cmd == slnm_pkg::CMD_CLEAR);
    assign is_sample = (cmd == slnm_pkg::CMD_SAMPLE);
    assign is_last   = (pos_reg >= last_pos);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept && is_sample)
        begin
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (en)
            begin
                a_valid_reg <= in_valid && known_cmd;
            end
        end
    end

    // Stage A: register the three products and the sample fields.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kind_reg <= slnm_pkg::cmd_t'(cmd);
            p_c_reg    <= time_base * line_freq;
            p_l_reg    <= time_base * left_wing;
            p_r_reg    <= time_base * right_wing;
            a_re_reg   <= sample_re;
            a_im_reg   <= sample_im;
            a_bin_reg  <= {1'b0, min_bin} + {1'b0, pos_reg};
            a_last_reg <= is_last;
        end
    end

    // Stage B: round centre to nearest (half up), floor the wings.
    always_comb
    begin
        c_up   = {1'b0, p_c_reg[slnm_pkg::PROD_W-1:35]} + 30'd1;
        c_full = c_up[slnm_pkg::BIN_W+1:1];
        centre = c_full[slnm_pkg::BIN_W] ? '1 : c_full[slnm_pkg::BIN_W-1:0];
        lw     = p_l_reg[slnm_pkg::PROD_W-1:36];
        rw     = p_r_reg[slnm_pkg::PROD_W-1:36];

        tok_next            = '0;
        tok_next.valid      = a_valid_reg;
        tok_next.kind       = a_kind_reg;
        tok_next.taken      = 1'b0;
        tok_next.centre     = centre;
        tok_next.left_bins  = lw;
        tok_next.right_bins = rw;
        tok_next.lo_edge    = $signed({1'b0, centre}) - $signed({1'b0, lw});
        tok_next.hi_edge    = {1'b0, centre} + {1'b0, rw};
        tok_next.re         = a_re_reg;
        tok_next.im         = a_im_reg;
        tok_next.bin        = a_bin_reg;
        tok_next.last       = a_last_reg;
        tok_next.hit        = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

### rtl/slnm_cell.sv
// One line slot of the masking chain: stores a line, tests passing samples.
// Depends on slnm_pkg; instantiated in a row by the top level.
module slnm_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  slnm_pkg::band_t   band,
    input  slnm_pkg::token_t  tok_in,
    output slnm_pkg::token_t  tok_out
);

    logic                               occ_reg;
    logic [slnm_pkg::BIN_W-1:0]         c_reg;
    logic [slnm_pkg::BIN_W-1:0]         l_reg;
    logic [slnm_pkg::BIN_W-1:0]         r_reg;
    logic signed [slnm_pkg::BIN_W:0]    lo_reg;
    logic [slnm_pkg::BIN_W:0]           hi_reg;
    slnm_pkg::token_t                   tok_reg;
    slnm_pkg::token_t                   tok_next;

    logic                               grab;
    logic                               wipe;
    logic                               in_band;
    logic                               wings_ok;
    logic                               in_range;
    logic                               match;

    assign grab = tok_in.valid && (tok_in.kind == slnm_pkg::CMD_LOAD)
                  && !tok_in.taken && !occ_reg;
    assign wipe = tok_in.valid && (tok_in.kind == slnm_pkg::CMD_CLEAR);

    assign in_band  = (c_reg >= {5'b0, band.lo}) && (c_reg <= {4'b0, band.hi});
    assign wings_ok = (l_reg <= {12'b0, band.max_wing}) && (r_reg <= {12'b0, band.max_wing});
    assign in_range = ($signed({6'b0, tok_in.bin}) >= $signed({lo_reg[slnm_pkg::BIN_W], lo_reg}))
                      && ({5'b0, tok_in.bin} <= hi_reg);
    assign match    = occ_reg && in_band && wings_ok && in_range;

    always_comb
    begin
        tok_next = tok_in;
        if (grab)
        begin
            tok_next.taken = 1'b1;
        end
        if (tok_in.valid && (tok_in.kind == slnm_pkg::CMD_SAMPLE))
        begin
            tok_next.hit = tok_in.hit || match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            tok_reg <= '0;
        end
        else if (en)
        begin
            tok_reg <= tok_next;
            if (wipe)
            begin
                occ_reg <= 1'b0;
            end
            else if (grab)
            begin
                occ_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && grab)
        begin
            c_reg  <= tok_in.centre;
            l_reg  <= tok_in.left_bins;
            r_reg  <= tok_in.right_bins;
            lo_reg <= tok_in.lo_edge;
            hi_reg <= tok_in.hi_edge;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/spectral_line_notch_masker_core.sv
// Spectral line notch masker: takes one item per cycle unless the output stalls;
// each sample passes two entry stages for the Hz-to-bin multiply and rounding,
// then one register per line cell, before its result appears. Every item,
// load, clear or sample, walks the same row of line cells, so loads and clears
// act in order with the samples around them. The whole row advances together and
// holds only while a result sits unclaimed on the output. A load that reaches the
// end of the row without finding a free cell sets the sticky dropped flag.
// Depends on slnm_pkg, slnm_front and slnm_cell.
module spectral_line_notch_masker_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // line_freq[31:0], left_wing[63:32], right_wing[95:64],
    // sample_re[127:96], sample_im[159:128]
    input  logic [159:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_re[31:0], out_im[63:32], bin_number[87:64]
    output logic [87:0]   m_axis_tdata,
    // masked[0], lines_dropped[1]
    output logic [1:0]    m_axis_tuser,
    output logic          m_axis_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    logic [slnm_pkg::POS_W-1:0]      min_bin_reg;
    logic [slnm_pkg::BINNUM_W-1:0]   num_bins_reg;
    logic [slnm_pkg::WING_MAX_W-1:0] max_wing_reg;
    logic [slnm_pkg::TB_W-1:0]       time_base_reg;
    logic                            dropped_reg;

    logic [slnm_pkg::POS_W-1:0]      last_pos;
    logic                            en;
    logic                            out_valid;
    slnm_pkg::band_t                 band;
    slnm_pkg::token_t                chain [slnm_pkg::MAX_LINES+1];
    slnm_pkg::token_t                tail;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_bin_reg   <= '0;
            num_bins_reg  <= 24'd1024;
            max_wing_reg  <= '0;
            time_base_reg <= 32'd117964800;
        end
        else if (cfg_valid)
        begin
            unique case (slnm_pkg::reg_index_t'(cfg_index))
                slnm_pkg::REG_MIN_BIN:       min_bin_reg   <= cfg_data[slnm_pkg::POS_W-1:0];
                slnm_pkg::REG_NUM_BINS:      num_bins_reg  <= cfg_data[slnm_pkg::BINNUM_W-1:0];
                slnm_pkg::REG_MAX_WING_BINS: max_wing_reg  <= cfg_data[slnm_pkg::WING_MAX_W-1:0];
                slnm_pkg::REG_TIME_BASE:     time_base_reg <= cfg_data;
                default:                     min_bin_reg   <= min_bin_reg;
            endcase
        end
    end

    // Last position of the spectrum: zero bins acts as one, bin count clamps at 2^23.
    always_comb
    begin
        priority if (num_bins_reg == '0)
        begin
            last_pos = '0;
        end
        else if (num_bins_reg[slnm_pkg::BINNUM_W-1])
        begin
            last_pos = '1;
        end
        else
        begin
            last_pos = num_bins_reg[slnm_pkg::POS_W-1:0] - 1'b1;
        end
    end

    assign band.lo       = min_bin_reg;
    assign band.hi       = {1'b0, min_bin_reg} + {1'b0, last_pos};
    assign band.max_wing = max_wing_reg;

    assign tail      = chain[slnm_pkg::MAX_LINES];
    assign out_valid = tail.valid && (tail.kind == slnm_pkg::CMD_SAMPLE);
    assign en        = !out_valid || m_axis_tready;

    assign s_axis_tready = en;

    slnm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .cmd        (s_axis_tuser),
        .line_freq  (s_axis_tdata[31:0]),
        .left_wing  (s_axis_tdata[63:32]),
        .right_wing (s_axis_tdata[95:64]),
        .sample_re  (s_axis_tdata[127:96]),
        .sample_im  (s_axis_tdata[159:128]),
        .min_bin    (min_bin_reg),
        .last_pos   (last_pos),
        .time_base  (time_base_reg),
        .tok        (chain[0])
    );

    for (genvar g = 0; g < slnm_pkg::MAX_LINES; g++)
    begin : g_cell
        slnm_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .band    (band),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // Drop: a load that left the row unstored found the table full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dropped_reg <= 1'b0;
        end
        else if (en && tail.valid && (tail.kind == slnm_pkg::CMD_LOAD) && !tail.taken)
        begin
            dropped_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid       = out_valid;
    assign m_axis_tdata[31:0]  = tail.hit ? '0 : tail.re;
    assign m_axis_tdata[63:32] = tail.hit ? '0 : tail.im;
    assign m_axis_tdata[87:64] = tail.bin;
    assign m_axis_tuser[0]     = tail.hit;
    assign m_axis_tuser[1]     = dropped_reg;
    assign m_axis_tlast        = tail.last;

endmodule

### bench/tb_spectral_line_notch_masker_core.sv
// Self-checking bench for spectral_line_notch_masker_core: line loads, clears and
// spectrum samples over many register settings, checked against a local predictor.
// Depends on slnm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_spectral_line_notch_masker_core;

    import slnm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int OVERFLOW_PHASE = 6;
    localparam int DRAIN_CYCLES   = 3 * (MAX_LINES + 2);
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_A      = 200;
    localparam int HOLD_AT_B      = 700;
    localparam int TIMEOUT_NS     = 5_000_000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] freq;
        logic [31:0] lwing;
        logic [31:0] rwing;
        logic [31:0] re;
        logic [31:0] im;
    } spec_item_t;

    typedef struct {
        logic [31:0]         re;
        logic [31:0]         im;
        logic                masked;
        logic [BINNUM_W-1:0] bin;
        logic                last;
        logic                dropped;
    } bin_result_t;

    logic          clk;
    logic          rst_n         = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [159:0]  s_axis_tdata  = '0;
    logic [1:0]    s_axis_tuser  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [87:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          m_axis_tlast;
    logic          cfg_valid     = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index     = '0;
    logic [31:0]   cfg_data      = '0;

    // predictor state: registers, line table, stream position
    logic [POS_W-1:0]      reg_min_bin   = '0;
    logic [23:0]           reg_num_bins  = 24'd1024;
    logic [WING_MAX_W-1:0] reg_max_wing  = '0;
    logic [TB_W-1:0]       reg_time_base = 32'd117964800;
    logic [BIN_W-1:0]      line_centre [MAX_LINES];
    logic [BIN_W-1:0]      line_left   [MAX_LINES];
    logic [BIN_W-1:0]      line_right  [MAX_LINES];
    int unsigned           lines_held = 0;
    logic [POS_W-1:0]      bin_pos    = '0;
    logic                  drop_flag  = 1'b0;

    spec_item_t  pending_items [$];
    bin_result_t expected_bins [$];

    int errors     = 0;
    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_masked   = 0;
    int n_last     = 0;
    int gen_lines  = 0;
    int tx_gap     = 0;
    int rx_stall   = 0;
    int hold_left  = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    spectral_line_notch_masker_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned band_size();
        int unsigned n;
        n = reg_num_bins;
        if (n == 0)
            n = 1;
        if (n > 32'h80_0000)
            n = 32'h80_0000;
        return n;
    endfunction

    // Q16.16 seconds times Q12.20 Hz gives bins in Q28.36
    function automatic logic [BIN_W-1:0] centre_bin_of(logic [31:0] hz);
        logic [63:0] prod;
        logic [29:0] rounded;
        prod    = 64'(reg_time_base) * 64'(hz);
        rounded = (30'(prod >> 35) + 30'd1) >> 1;
        if (rounded > 30'h0FFF_FFFF)
            return '1;
        return rounded[BIN_W-1:0];
    endfunction

    function automatic logic [BIN_W-1:0] wing_bins_of(logic [31:0] hz);
        logic [63:0] prod;
        prod = 64'(reg_time_base) * 64'(hz);
        return prod[63:36];
    endfunction

    function automatic void advance_notch(spec_item_t it);
        int unsigned n;
        longint      lo, hi, binv, c, l, r;
        logic        hit;
        logic        is_last;
        bin_result_t res;
        case (it.cmd)
            CMD_LOAD:
            begin
                if (lines_held >= MAX_LINES)
                    drop_flag = 1'b1;
                else
                begin
                    line_centre[lines_held] = centre_bin_of(it.freq);
                    line_left[lines_held]   = wing_bins_of(it.lwing);
                    line_right[lines_held]  = wing_bins_of(it.rwing);
                    lines_held++;
                end
            end
            CMD_CLEAR:
                lines_held = 0;
            CMD_SAMPLE:
            begin
                n    = band_size();
                lo   = reg_min_bin;
                hi   = lo + longint'(n) - 1;
                binv = lo + longint'(bin_pos);
                hit  = 1'b0;
                for (int i = 0; i < lines_held; i++)
                begin
                    c = line_centre[i];
                    l = line_left[i];
                    r = line_right[i];
                    if (c >= lo && c <= hi && l <= longint'(reg_max_wing) &&
                        r <= longint'(reg_max_wing) && binv >= c - l && binv <= c + r)
                        hit = 1'b1;
                end
                is_last     = (bin_pos >= n - 1);
                res.re      = hit ? '0 : it.re;
                res.im      = hit ? '0 : it.im;
                res.masked  = hit;
                res.bin     = binv[BINNUM_W-1:0];
                res.last    = is_last;
                res.dropped = drop_flag;
                expected_bins.push_back(res);
                bin_pos = is_last ? '0 : bin_pos + 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic spec_item_t fresh_item(logic [1:0] cmd);
        spec_item_t it;
        it.cmd   = cmd;
        it.freq  = $urandom;
        it.lwing = $urandom;
        it.rwing = $urandom;
        it.re    = pick_sample();
        it.im    = pick_sample();
        return it;
    endfunction

    function automatic spec_item_t load_hz(logic [31:0] f, logic [31:0] lw, logic [31:0] rw);
        spec_item_t it;
        it       = fresh_item(CMD_LOAD);
        it.freq  = f;
        it.lwing = lw;
        it.rwing = rw;
        return it;
    endfunction

    // Hz that lands on a Q28.36 bin target; nudge down now and then to hit the edge
    function automatic logic [31:0] hz_at(logic [63:0] target);
        logic [63:0] q;
        if (reg_time_base == 0)
            return $urandom;
        q = (target + 64'(reg_time_base) - 1) / 64'(reg_time_base);
        if (q > 64'hFFFF_FFFF)
            return $urandom;
        if (q != 0 && $urandom_range(0, 3) == 0)
            q = q - 1;
        return q[31:0];
    endfunction

    function automatic void queue_item(spec_item_t it);
        pending_items.push_back(it);
        if (it.cmd != CMD_UNUSED)
            n_queued++;
        if (it.cmd == CMD_LOAD && gen_lines < MAX_LINES)
            gen_lines++;
        if (it.cmd == CMD_CLEAR)
            gen_lines = 0;
    endfunction

    // aim a line at the band, sometimes just outside it or with a too-wide wing
    function automatic void add_line(int ph);
        longint unsigned lo, cbin;
        int unsigned     span, lb, rb, wmax;
        lo   = reg_min_bin;
        span = band_size();
        if (span > 64)
            span = 64;
        case ($urandom_range(0, 7))
            0: cbin = lo + band_size() + $urandom_range(0, 2);
            1: cbin = (lo > 0) ? lo - 1 : lo;
            default: cbin = lo + $urandom_range(0, span - 1);
        endcase
        wmax = (reg_max_wing > 6) ? 6 : reg_max_wing;
        lb   = $urandom_range(0, wmax + 1);
        rb   = $urandom_range(0, wmax + 1);
        // keep the table from filling before the overflow phase
        if (ph < OVERFLOW_PHASE && gen_lines == MAX_LINES)
            queue_item(fresh_item(CMD_CLEAR));
        queue_item(load_hz(hz_at((cbin == 0) ? 64'd0 : (cbin << 36) - (64'd1 << 35)),
                           hz_at(64'(lb) << 36), hz_at(64'(rb) << 36)));
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN_BIN:       reg_min_bin   = value[POS_W-1:0];
            REG_NUM_BINS:      reg_num_bins  = value[23:0];
            REG_MAX_WING_BINS: reg_max_wing  = value[WING_MAX_W-1:0];
            REG_TIME_BASE:     reg_time_base = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every result, then let loads and clears leave the cell row
    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_bins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int ph);
        logic [POS_W-1:0]      mb;
        logic [23:0]           nb;
        logic [WING_MAX_W-1:0] mw;
        logic [31:0]           tb;
        int unsigned           target, span;
        case (ph)
            0: begin mb = '0;          nb = 24'd1;        mw = '0;     tb = 32'd65536;     end
            1: begin mb = '1;          nb = 24'd40;       mw = '1;     tb = 32'hFFFF_FFFF; end
            2: begin mb = '0;          nb = 24'd0;        mw = 16'd3;  tb = 32'd0;         end
            3: begin mb = 23'($urandom_range(0, 100)); nb = 24'hFF_FFFF; mw = 16'd5;
                     tb = $urandom_range(1 << 15, 1 << 18); end
            4: begin mb = '1;          nb = 24'h80_0000;  mw = 16'd2;  tb = 32'd1;         end
            default:
            begin
                mb = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 3000));
                nb = 24'($urandom_range(2, 48));
                mw = 16'($urandom_range(0, 6));
                tb = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 12, 1 << 22);
            end
        endcase
        write_reg(REG_MIN_BIN, 32'(mb));
        write_reg(REG_NUM_BINS, 32'(nb));
        write_reg(REG_MAX_WING_BINS, 32'(mw));
        write_reg(REG_TIME_BASE, tb);
        tx_quiet = (ph % 4 == 1) || (ph % 4 == 3);
        rx_quiet = (ph % 4 == 2) || (ph % 4 == 3);
        target   = n_queued + PHASE_ITEMS;
        // largest line frequency: centre overflows 28 bits and saturates
        if (ph == 1)
            queue_item(load_hz('1, '1, '1));
        if (ph == OVERFLOW_PHASE)
        begin
            queue_item(fresh_item(CMD_CLEAR));
            repeat (MAX_LINES + 3) add_line(ph);
        end
        else if ($urandom_range(0, 9) < 6)
            queue_item(fresh_item(CMD_CLEAR));
        while (n_queued < target)
        begin
            repeat ($urandom_range(0, 3)) add_line(ph);
            span = band_size();
            if (span > 64)
                span = 64;
            repeat ($urandom_range(1, 2 * span)) queue_item(fresh_item(CMD_SAMPLE));
            case ($urandom_range(0, 9))
                0: queue_item(fresh_item(CMD_UNUSED));
                1: queue_item(fresh_item(CMD_CLEAR));
                default:
                begin
                end
            endcase
        end
        settle();
    endtask

    // ---------------------------------------------------------------- input driver

    always @(negedge clk)
    begin : drive_input
        spec_item_t it;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (tx_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                s_axis_tdata  <= {it.im, it.re, it.rwing, it.lwing, it.freq};
                s_axis_tuser  <= it.cmd;
                s_axis_tvalid <= 1'b1;
                tx_gap        <= tx_quiet ? 0 : $urandom_range(0, 6);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- output receiver

    always @(negedge clk)
    begin : drive_ready
        int pause;
        if (rst_n)
        begin
            pause = rx_quiet ? 0 : $urandom_range(0, 6);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (rx_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall      <= rx_stall - 1;
            end
            else if (out_fire && (n_results == HOLD_AT_A || n_results == HOLD_AT_B))
            begin
                // long hold-off: let the cell row fill and back up the input
                m_axis_tready <= 1'b0;
                hold_left     <= LONG_HOLD;
            end
            else if (out_fire && pause > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_stall      <= pause - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : watch_ports
        spec_item_t  got_in;
        bin_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bins.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transfer, expected none, got tdata %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = expected_bins.pop_front();
                    check_field("out_re", want.re, m_axis_tdata[31:0]);
                    check_field("out_im", want.im, m_axis_tdata[63:32]);
                    check_field("bin_number", 32'(want.bin), 32'(m_axis_tdata[87:64]));
                    check_field("masked", 32'(want.masked), 32'(m_axis_tuser[0]));
                    check_field("lines_dropped", 32'(want.dropped), 32'(m_axis_tuser[1]));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                end
                n_results++;
                if (m_axis_tuser[0])
                    n_masked++;
                if (m_axis_tlast)
                    n_last++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                got_in.cmd   = s_axis_tuser;
                got_in.freq  = s_axis_tdata[31:0];
                got_in.lwing = s_axis_tdata[63:32];
                got_in.rwing = s_axis_tdata[95:64];
                got_in.re    = s_axis_tdata[127:96];
                got_in.im    = s_axis_tdata[159:128];
                advance_notch(got_in);
                n_accepted++;
            end
            in_fire  <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        int         k;
        spec_item_t it;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one Hz per bin, twelve-bin spectrum, wings up to four bins
        write_reg(REG_NUM_BINS, 32'd12);
        write_reg(REG_MAX_WING_BINS, 32'd4);
        write_reg(REG_TIME_BASE, 32'd65536);
        queue_item(load_hz(32'd5 << 20, 32'd1 << 20, 32'd2 << 20));
        // half a bin rounds up
        queue_item(load_hz((32'd5 << 20) | (32'd1 << 19), '0, '0));
        // just under half rounds down; left wing too wide to count
        queue_item(load_hz((32'd9 << 20) | ((32'd1 << 19) - 1), 32'd5 << 20, '0));
        // centre beyond the band
        queue_item(load_hz(32'd30 << 20, '0, '0));
        it       = fresh_item(CMD_UNUSED);
        it.freq  = '1;
        it.lwing = '1;
        it.rwing = '1;
        queue_item(it);
        for (k = 0; k < 12; k++)
        begin
            it       = fresh_item(CMD_SAMPLE);
            it.re    = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            it.im    = k[0] ? 32'h0000_0000 : 32'hFFFF_FFFF;
            it.freq  = k[0] ? '0 : '1;
            it.lwing = k[0] ? '1 : '0;
            it.rwing = k[0] ? '0 : '1;
            queue_item(it);
        end
        queue_item(fresh_item(CMD_CLEAR));
        queue_item(fresh_item(CMD_SAMPLE));
        // centre at bin zero with the left edge below zero
        queue_item(load_hz('0, 32'd3 << 20, (32'd4 << 20) | 32'h000F_FFFF));
        queue_item(fresh_item(CMD_SAMPLE));
        settle();

        for (k = 0; k < NUM_PHASES; k++)
            run_phase(k);

        $display("Checked %0d spectrum bins from %0d accepted items over %0d register settings",
                 n_results, n_accepted, NUM_PHASES + 1);
        $display("%0d bins masked, %0d spectrum ends, table overflow flag %0b",
                 n_masked, n_last, drop_flag);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected", expected_bins.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
